@@ hw/rtl/scpt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scpt_pkg
// Types, constants and helpers shared by the solenoid current PID trim core.
// ----------------------------------------------------------------------------
package scpt_pkg;

    localparam int CUR_W    = 16;
    localparam int OFFS_W   = 12;
    localparam int GAIN_W   = 16;
    localparam int DUTY_W   = 13;
    localparam int TRIM_W   = 16;
    localparam int IDX_W    = 3;
    localparam int CFG_W    = 16;

    // The error is at most 1000 * 65535 in magnitude.
    localparam int ERR_W    = 27;
    localparam int MUL_A_W  = 28;
    localparam int MUL_B_W  = 17;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;
    localparam int ACC_W    = 36;
    localparam int DEN_W    = 16;

    localparam int BATTERY_MIN_MV = 9000;
    localparam int PID_MIN_MA     = 200;
    localparam int PER_MILLE      = 1000;
    localparam int DUTY_FULL      = 4096;
    localparam int TRIM_MAX       = 32767;
    localparam int TRIM_MIN       = -32768;

    typedef enum logic [IDX_W-1:0] {
        REG_MAX_CURRENT    = 3'd0,
        REG_CURRENT_OFFSET = 3'd1,
        REG_GAIN_P         = 3'd2,
        REG_GAIN_I         = 3'd3,
        REG_GAIN_D         = 3'd4
    } cfg_reg_t;

    typedef enum logic [2:0] {
        MUL_ERR,
        MUL_P,
        MUL_I,
        MUL_D,
        MUL_DUTY
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BRANCH,
        ST_ERR_GO,
        ST_ERR_WAIT,
        ST_P_GO,
        ST_P_WAIT,
        ST_I_UPD,
        ST_I_GO,
        ST_I_WAIT,
        ST_D_GO,
        ST_D_WAIT,
        ST_TRIM,
        ST_DUTY_GO,
        ST_DUTY_WAIT,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic     load_item;
        logic     div_start;
        mul_sel_t mul_sel;
        logic     div_by_max;
        logic     err_cap;
        logic     acc_load;
        logic     acc_add;
        logic     int_upd;
        logic     trim_upd;
        logic     duty_cap;
        logic     out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic drive_on;
        logic pid_en;
        logic div_done;
        logic out_busy;
    } dp_status_t;

    function automatic logic signed [TRIM_W-1:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [TRIM_W-1:0] r;
        if (v > ACC_W'(TRIM_MAX)) begin
            r = TRIM_W'(TRIM_MAX);
        end else if (v < ACC_W'(TRIM_MIN)) begin
            r = TRIM_W'(TRIM_MIN);
        end else begin
            r = v[TRIM_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/scpt_in_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scpt_in_if
// Request channel carrying one current reading.
// ----------------------------------------------------------------------------
interface scpt_in_if import scpt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CUR_W-1:0]  battery_mv;
    logic [CUR_W-1:0]  raw_current_ma;
    logic [CUR_W-1:0]  target_current_ma;

    modport source (output valid, output battery_mv, output raw_current_ma,
                    output target_current_ma, input ready);
    modport sink   (input valid, input battery_mv, input raw_current_ma,
                    input target_current_ma, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/scpt_out_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scpt_out_if
// Result channel carrying the PWM duty and the trim in force.
// ----------------------------------------------------------------------------
interface scpt_out_if import scpt_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [DUTY_W-1:0]        pwm_duty;
    logic signed [TRIM_W-1:0] trim_value;

    modport source (output valid, output pwm_duty, output trim_value, input ready);
    modport sink   (input valid, input pwm_duty, input trim_value, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/scpt_cfg_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scpt_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface scpt_cfg_if import scpt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] reg_index;
    logic [CFG_W-1:0] wdata;

    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/solenoid_current_pid_trim_core.sv @@
// Path: with drive off a request goes straight to the result; without a PID
// update only the error and duty divisions run; with one the P, I and D terms run too.
// Throughput: one reading at a time; the 45-bit divider, one quotient bit per
// cycle, runs the two divisions by full scale, while the three divisions by
// 1000 take a four-step reciprocal multiply each.
// A finished result sits in the output register while the next request enters.
// Reset (rst_n, asynchronous): configuration registers, saved target, PID state and trim clear to 0.
`default_nettype none
// ----------------------------------------------------------------------------
// solenoid_current_pid_trim_core
// Constant-current solenoid driver: PID trim with feedforward duty.
// ----------------------------------------------------------------------------
module solenoid_current_pid_trim_core import scpt_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    scpt_in_if.sink    in_ch,
    scpt_out_if.source out_ch,
    scpt_cfg_if.sink   cfg_ch
);

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       in_ready;

    assign in_ch.ready = in_ready;

    scpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    scpt_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .battery_mv        (in_ch.battery_mv),
        .raw_current_ma    (in_ch.raw_current_ma),
        .target_current_ma (in_ch.target_current_ma),
        .cmd               (cmd),
        .status            (status),
        .cfg_ch            (cfg_ch),
        .out_ch            (out_ch)
    );

endmodule
`default_nettype wire

@@ hw/rtl/scpt_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scpt_div
// Shared restoring divider: signed dividend by positive divisor, one quotient
// bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module scpt_div import scpt_pkg::*; (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [PROD_W-1:0] dividend,
    input  wire logic [DEN_W-1:0]         divisor,
    output      logic                     done,
    output      logic signed [PROD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [PROD_W-1:0] q_reg, q_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg;
    logic              neg_reg;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              prep_reg, prep_next;
    logic              done_reg, done_next;
    logic [DEN_W:0]    rem_sh;
    logic              fits;

    always_comb
    begin
        rem_sh    = {rem_reg, q_reg[PROD_W-1]};
        fits      = rem_sh >= {1'b0, den_reg};
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        prep_next = prep_reg;
        done_next = 1'b0;
        if (busy_reg && prep_reg) begin
            // Work on the magnitude; the sign is restored at the output.
            if (neg_reg) begin
                q_next = -q_reg;
            end
            prep_next = 1'b0;
        end else if (busy_reg) begin
            rem_next = fits ? DEN_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DEN_W-1:0];
            q_next   = {q_reg[PROD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            prep_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            if (start) begin
                busy_reg <= 1'b1;
                prep_reg <= 1'b1;
                cnt_reg  <= CNT_W'(PROD_W);
            end else begin
                busy_reg <= busy_next;
                prep_reg <= prep_next;
                cnt_reg  <= cnt_next;
            end
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            q_reg   <= dividend;
            neg_reg <= dividend[PROD_W-1];
            den_reg <= divisor;
            rem_reg <= '0;
        end else begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed(q_reg) : $signed(q_reg);

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg) else $error("divider started while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("divider done held high");
    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !prep_reg) |-> (cnt_reg != '0)) else $error("divider count ran out");

endmodule
`default_nettype wire

@@ hw/rtl/scpt_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scpt_datapath
// Configuration registers, PID state, shared multiplier and divider, and the
// output register.
// ----------------------------------------------------------------------------
module scpt_datapath import scpt_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CUR_W-1:0] battery_mv,
    input  wire logic [CUR_W-1:0] raw_current_ma,
    input  wire logic [CUR_W-1:0] target_current_ma,
    input  wire ctrl_cmd_t        cmd,
    output      dp_status_t       status,
    scpt_cfg_if.sink              cfg_ch,
    scpt_out_if.source            out_ch
);

    // Division by 1000 as a reciprocal multiplication: a / 1000 equals
    // (a >> 3) / 125, and (b * K_RECIP) >> 48 equals b / 125 for every b
    // below 2^41. The product is built from four 21 x 21 partial products.
    localparam int                    K_HALF_W = 21;
    localparam int                    K_ACC_W  = 44;
    localparam int                    K_TAIL   = 6;
    localparam logic [2*K_HALF_W-1:0] K_RECIP  = 42'd2251799813686;

    logic [CUR_W-1:0]          max_reg;
    logic signed [OFFS_W-1:0]  offs_reg;
    logic signed [GAIN_W-1:0]  gp_reg, gi_reg, gd_reg;

    logic [CUR_W-1:0]          target_reg, obs_reg, prev_reg, saved_target_reg;
    logic                      drive_on_reg, pid_en_reg;
    logic signed [ERR_W-1:0]   err_reg, prev_err_reg;
    logic signed [TRIM_W-1:0]  integ_reg, trim_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [DUTY_W-1:0]         duty_reg;
    logic                      out_valid_reg;
    logic [DUTY_W-1:0]         out_duty_reg;
    logic signed [TRIM_W-1:0]  out_trim_reg;

    logic signed [CUR_W+1:0]   obs_sum;
    logic [CUR_W-1:0]          obs_clamp;
    logic                      drive_on_w;
    logic signed [CUR_W:0]     cur_diff;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  quot;
    logic                      div_done;

    logic                      md_start;
    logic                      md_done;
    logic signed [PROD_W-1:0]  md_quot;

    logic                      kd_start;
    logic                      kd_busy_reg;
    logic [1:0]                kd_step_reg;
    logic                      kd_done_reg;
    logic                      kd_neg_reg;
    logic [2*K_HALF_W-1:0]     kd_b_reg;
    logic [K_ACC_W-1:0]        kd_acc_reg;
    logic [PROD_W-1:0]         kd_mag;
    logic [K_HALF_W-1:0]       kd_op_b;
    logic [K_HALF_W-1:0]       kd_op_m;
    logic [2*K_HALF_W-1:0]     kd_pp;
    logic [K_ACC_W-1:0]        kd_acc_next;
    logic [PROD_W-1:0]         kd_qmag;
    logic signed [PROD_W-1:0]  kd_quot;

    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_reg  <= '0;
            offs_reg <= '0;
            gp_reg   <= '0;
            gi_reg   <= '0;
            gd_reg   <= '0;
        end else if (cfg_ch.valid) begin
            unique case (cfg_reg_t'(cfg_ch.reg_index))
                REG_MAX_CURRENT:    max_reg  <= cfg_ch.wdata;
                REG_CURRENT_OFFSET: offs_reg <= cfg_ch.wdata[OFFS_W-1:0];
                REG_GAIN_P:         gp_reg   <= cfg_ch.wdata;
                REG_GAIN_I:         gi_reg   <= cfg_ch.wdata;
                REG_GAIN_D:         gd_reg   <= cfg_ch.wdata;
                default:            ;
            endcase
        end
    end

    // Offset-corrected current, held inside 0..65535.
    always_comb
    begin
        obs_sum = $signed({2'b00, raw_current_ma}) + (CUR_W+2)'(offs_reg);
        if (obs_sum < 0) begin
            obs_clamp = '0;
        end else if (obs_sum[CUR_W]) begin
            obs_clamp = '1;
        end else begin
            obs_clamp = obs_sum[CUR_W-1:0];
        end
        drive_on_w = (battery_mv > CUR_W'(BATTERY_MIN_MV)) && (target_current_ma != '0)
                     && (max_reg != '0);
    end

    always_comb
    begin
        cur_diff = $signed({1'b0, prev_reg}) - $signed({1'b0, obs_reg});
        unique case (cmd.mul_sel)
            MUL_ERR:
            begin
                mul_a = MUL_A_W'(cur_diff);
                mul_b = MUL_B_W'(PER_MILLE);
            end
            MUL_P:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = MUL_B_W'(gp_reg);
            end
            MUL_I:
            begin
                mul_a = MUL_A_W'(integ_reg);
                mul_b = MUL_B_W'(gi_reg);
            end
            MUL_D:
            begin
                mul_a = MUL_A_W'(err_reg) - MUL_A_W'(prev_err_reg);
                mul_b = MUL_B_W'(gd_reg);
            end
            MUL_DUTY:
            begin
                mul_a = MUL_A_W'(trim_reg) + MUL_A_W'(DUTY_FULL);
                mul_b = $signed({1'b0, target_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;
    end

    assign md_start = cmd.div_start && cmd.div_by_max;
    assign kd_start = cmd.div_start && !cmd.div_by_max;

    // The divider registers the product as it starts.
    scpt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (md_start),
        .dividend (prod),
        .divisor  (max_reg),
        .done     (md_done),
        .quotient (md_quot)
    );

    // Divide by 1000: the magnitude is multiplied by the reciprocal one
    // partial product per cycle, and the sign is restored at the output.
    always_comb
    begin
        kd_mag = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
        unique case (kd_step_reg)
            2'd0:
            begin
                kd_op_b = kd_b_reg[K_HALF_W-1:0];
                kd_op_m = K_RECIP[K_HALF_W-1:0];
            end
            2'd1:
            begin
                kd_op_b = kd_b_reg[K_HALF_W-1:0];
                kd_op_m = K_RECIP[2*K_HALF_W-1:K_HALF_W];
            end
            2'd2:
            begin
                kd_op_b = kd_b_reg[2*K_HALF_W-1:K_HALF_W];
                kd_op_m = K_RECIP[K_HALF_W-1:0];
            end
            2'd3:
            begin
                kd_op_b = kd_b_reg[2*K_HALF_W-1:K_HALF_W];
                kd_op_m = K_RECIP[2*K_HALF_W-1:K_HALF_W];
            end
        endcase
        kd_pp = kd_op_b * kd_op_m;
        unique case (kd_step_reg)
            2'd0:    kd_acc_next = K_ACC_W'(kd_pp);
            2'd1:    kd_acc_next = (kd_acc_reg >> K_HALF_W) + K_ACC_W'(kd_pp);
            2'd2:    kd_acc_next = kd_acc_reg + K_ACC_W'(kd_pp);
            2'd3:    kd_acc_next = (kd_acc_reg >> K_HALF_W) + K_ACC_W'(kd_pp);
        endcase
        kd_qmag = PROD_W'(kd_acc_reg >> K_TAIL);
        kd_quot = kd_neg_reg ? -$signed(kd_qmag) : $signed(kd_qmag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            kd_busy_reg <= 1'b0;
            kd_step_reg <= '0;
            kd_done_reg <= 1'b0;
        end else begin
            kd_done_reg <= kd_busy_reg && (kd_step_reg == 2'd3);
            if (kd_start) begin
                kd_busy_reg <= 1'b1;
                kd_step_reg <= '0;
            end else if (kd_busy_reg) begin
                kd_busy_reg <= (kd_step_reg != 2'd3);
                kd_step_reg <= kd_step_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (kd_start) begin
            kd_b_reg   <= kd_mag[PROD_W-1:3];
            kd_neg_reg <= prod[PROD_W-1];
        end else if (kd_busy_reg) begin
            kd_acc_reg <= kd_acc_next;
        end
    end

    assign div_done = md_done || kd_done_reg;
    assign quot     = kd_done_reg ? kd_quot : md_quot;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            saved_target_reg <= '0;
            drive_on_reg     <= 1'b0;
            pid_en_reg       <= 1'b0;
            prev_err_reg     <= '0;
            integ_reg        <= '0;
            trim_reg         <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cmd.load_item) begin
                drive_on_reg     <= drive_on_w;
                pid_en_reg       <= (saved_target_reg >= CUR_W'(PID_MIN_MA))
                                    && (obs_clamp >= CUR_W'(PID_MIN_MA));
                saved_target_reg <= drive_on_w ? target_current_ma : '0;
            end
            if (cmd.int_upd) begin
                integ_reg <= sat16(ACC_W'(integ_reg) + ACC_W'(err_reg));
            end
            if (cmd.trim_upd) begin
                trim_reg     <= sat16(acc_reg);
                prev_err_reg <= err_reg;
            end
            if (cmd.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (out_ch.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item) begin
            target_reg <= target_current_ma;
            obs_reg    <= obs_clamp;
            prev_reg   <= saved_target_reg;
            duty_reg   <= '0;
        end
        if (cmd.err_cap) begin
            err_reg <= quot[ERR_W-1:0];
        end
        if (cmd.acc_load) begin
            acc_reg <= ACC_W'(quot);
        end else if (cmd.acc_add) begin
            acc_reg <= acc_reg + ACC_W'(quot);
        end
        if (cmd.duty_cap) begin
            if (quot < 0) begin
                duty_reg <= '0;
            end else if (quot > PROD_W'(DUTY_FULL)) begin
                duty_reg <= DUTY_W'(DUTY_FULL);
            end else begin
                duty_reg <= quot[DUTY_W-1:0];
            end
        end
        if (cmd.out_load) begin
            out_duty_reg <= duty_reg;
            out_trim_reg <= trim_reg;
        end
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.pwm_duty   = out_duty_reg;
    assign out_ch.trim_value = out_trim_reg;

    assign status.drive_on = drive_on_reg;
    assign status.pid_en   = pid_en_reg;
    assign status.div_done = div_done;
    assign status.out_busy = out_valid_reg && !out_ch.ready;

endmodule
`default_nettype wire

@@ hw/rtl/scpt_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// scpt_ctrl
// Sequencer: steps one reading through error, PID terms, trim and duty.
// ----------------------------------------------------------------------------
module scpt_ctrl import scpt_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output      logic       in_ready,
    input  wire dp_status_t status,
    output      ctrl_cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (in_valid) state_next = ST_BRANCH;
            ST_BRANCH:    state_next = status.drive_on ? ST_ERR_GO : ST_FINISH;
            ST_ERR_GO:    state_next = ST_ERR_WAIT;
            ST_ERR_WAIT:
            begin
                if (status.div_done) begin
                    state_next = status.pid_en ? ST_P_GO : ST_DUTY_GO;
                end
            end
            ST_P_GO:      state_next = ST_P_WAIT;
            ST_P_WAIT:    if (status.div_done) state_next = ST_I_UPD;
            ST_I_UPD:     state_next = ST_I_GO;
            ST_I_GO:      state_next = ST_I_WAIT;
            ST_I_WAIT:    if (status.div_done) state_next = ST_D_GO;
            ST_D_GO:      state_next = ST_D_WAIT;
            ST_D_WAIT:    if (status.div_done) state_next = ST_TRIM;
            ST_TRIM:      state_next = ST_DUTY_GO;
            ST_DUTY_GO:   state_next = ST_DUTY_WAIT;
            ST_DUTY_WAIT: if (status.div_done) state_next = ST_FINISH;
            ST_FINISH:    if (!status.out_busy) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        cmd.mul_sel  = MUL_ERR;
        in_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            ST_ERR_GO:
            begin
                cmd.mul_sel    = MUL_ERR;
                cmd.div_by_max = 1'b1;
                cmd.div_start  = 1'b1;
            end
            ST_ERR_WAIT:  cmd.err_cap = status.div_done;
            ST_P_GO:
            begin
                cmd.mul_sel   = MUL_P;
                cmd.div_start = 1'b1;
            end
            ST_P_WAIT:    cmd.acc_load = status.div_done;
            ST_I_UPD:     cmd.int_upd = 1'b1;
            ST_I_GO:
            begin
                cmd.mul_sel   = MUL_I;
                cmd.div_start = 1'b1;
            end
            ST_I_WAIT:    cmd.acc_add = status.div_done;
            ST_D_GO:
            begin
                cmd.mul_sel   = MUL_D;
                cmd.div_start = 1'b1;
            end
            ST_D_WAIT:    cmd.acc_add = status.div_done;
            ST_TRIM:      cmd.trim_upd = 1'b1;
            ST_DUTY_GO:
            begin
                cmd.mul_sel    = MUL_DUTY;
                cmd.div_by_max = 1'b1;
                cmd.div_start  = 1'b1;
            end
            ST_DUTY_WAIT: cmd.duty_cap = status.div_done;
            ST_FINISH:    cmd.out_load = !status.out_busy;
            default:      ;
        endcase
    end

endmodule
`default_nettype wire
